[rtl/mdet_pkg.sv]
// Package: shared constants, types and state encodings of the matrix determinant block.
`timescale 1ns / 1ps
`default_nettype none
package mdet_pkg;

    localparam int MAX_ORDER   = 8;
    localparam int ELEM_W      = 16;
    localparam int MAG_W       = 16;
    localparam int CFG_W       = 4;
    localparam int RES_W       = 64;
    localparam int ORD_W       = $clog2(MAX_ORDER + 1);
    localparam int IDX_W       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUBSETS     = 1 << MAX_ORDER;
    localparam int LIMB_W      = 32;
    localparam int LIMBS       = (MAX_ORDER * 17) / 32 + 2;
    localparam int LIMB_IW     = $clog2(LIMBS);
    localparam int ROW_W       = LIMBS * LIMB_W;
    localparam int MUL_W       = LIMB_W + MAG_W;
    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = 1;
    localparam int FCNT_W      = 2;
    localparam logic [CFG_W-1:0] ORDER_RESET = CFG_W'(2);

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic [ADDR_W-1:0]        addr;
        logic                     last;
        logic [ORD_W-1:0]         order;
    } entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_INIT,
        B_MASK,
        B_ROW,
        B_MAC,
        B_DONE
    } back_state_t;

endpackage
`default_nettype wire

[rtl/mdet_front.sv]
// Front end: holds the order register, counts loaded elements and tags each request.
`timescale 1ns / 1ps
`default_nettype none
module mdet_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    input  wire logic signed [mdet_pkg::ELEM_W-1:0]  element,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mdet_pkg::CFG_W-1:0]          cfg_wr_data,
    input  wire logic                                fifo_full,
    output logic                                     fifo_wr,
    output mdet_pkg::entry_t                         fifo_entry
);

    logic [mdet_pkg::CFG_W-1:0]   order_reg;
    logic [mdet_pkg::CNT_W-1:0]   cnt_reg;
    logic [mdet_pkg::CNT_W-1:0]   cnt_next;
    logic [mdet_pkg::ORD_W-1:0]   eff_order;
    logic [2*mdet_pkg::ORD_W-1:0] elem_total;
    logic                         last;

    always_comb
    begin
        if (order_reg == '0)
        begin
            eff_order = mdet_pkg::ORD_W'(1);
        end
        else if (32'(order_reg) > mdet_pkg::MAX_ORDER)
        begin
            eff_order = mdet_pkg::ORD_W'(mdet_pkg::MAX_ORDER);
        end
        else
        begin
            eff_order = mdet_pkg::ORD_W'(order_reg);
        end
        elem_total = (2*mdet_pkg::ORD_W)'(eff_order) * (2*mdet_pkg::ORD_W)'(eff_order);
        cnt_next   = cnt_reg + mdet_pkg::CNT_W'(1);
        last       = (32'(cnt_next) == 32'(elem_total));
    end

    assign fifo_wr                = push && !fifo_full;
    assign fifo_entry.element     = element;
    assign fifo_entry.addr        = cnt_reg[mdet_pkg::ADDR_W-1:0];
    assign fifo_entry.last        = last;
    assign fifo_entry.order       = eff_order;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= mdet_pkg::ORDER_RESET;
            cnt_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            order_reg <= cfg_wr_data;
            cnt_reg   <= '0;
        end
        else if (fifo_wr)
        begin
            cnt_reg <= last ? '0 : cnt_next;
        end
    end

endmodule
`default_nettype wire

[rtl/mdet_fifo.sv]
// Short request queue between the front end and the determinant engine.
`timescale 1ns / 1ps
`default_nettype none
module mdet_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire mdet_pkg::entry_t wr_entry,
    output logic                  full,
    input  wire logic             rd,
    output mdet_pkg::entry_t      rd_entry,
    output logic                  empty
);

    mdet_pkg::entry_t             mem [mdet_pkg::FIFO_DEPTH];
    logic [mdet_pkg::FPTR_W-1:0]  wr_ptr_reg;
    logic [mdet_pkg::FPTR_W-1:0]  rd_ptr_reg;
    logic [mdet_pkg::FCNT_W-1:0]  cnt_reg;
    logic                         do_wr;
    logic                         do_rd;

    assign full     = (32'(cnt_reg) == mdet_pkg::FIFO_DEPTH);
    assign empty    = (cnt_reg == '0);
    assign do_wr    = wr && !full;
    assign do_rd    = rd && !empty;
    assign rd_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + mdet_pkg::FPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + mdet_pkg::FPTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + mdet_pkg::FCNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - mdet_pkg::FCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/mdet_back.sv]
// Determinant engine: element store, minor table and limb-serial multiply-accumulate.
`timescale 1ns / 1ps
`default_nettype none
module mdet_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               fifo_empty,
    input  wire mdet_pkg::entry_t                   fifo_entry,
    output logic                                    fifo_rd,
    output logic signed [mdet_pkg::RES_W-1:0]       determinant,
    output logic                                    overflow,
    output logic                                    empty,
    input  wire logic                               pop
);

    logic [mdet_pkg::ELEM_W-1:0]  store_mem [mdet_pkg::STORE_DEPTH];
    logic [mdet_pkg::ROW_W-1:0]   minor_mem [mdet_pkg::SUBSETS];

    mdet_pkg::back_state_t        state_reg;
    mdet_pkg::back_state_t        state_next;
    logic [mdet_pkg::ORD_W-1:0]   order_reg;
    logic [mdet_pkg::MAX_ORDER-1:0] mask_reg;
    logic [mdet_pkg::ORD_W-1:0]   r_reg;
    logic [mdet_pkg::ORD_W-1:0]   pos_reg;
    logic [mdet_pkg::IDX_W-1:0]   c_reg;
    logic [mdet_pkg::LIMB_IW-1:0] limb_reg;
    logic [mdet_pkg::MAG_W-1:0]   mc_reg;
    logic                         ac_reg;
    logic [mdet_pkg::LIMB_W-1:0]  acc_reg [mdet_pkg::LIMBS];
    logic [mdet_pkg::ELEM_W-1:0]  store_q_reg;
    logic [mdet_pkg::ROW_W-1:0]   row_q_reg;
    logic                         out_valid_reg;
    logic [mdet_pkg::RES_W-1:0]   det_reg;
    logic                         ovf_reg;

    logic [mdet_pkg::MAX_ORDER-1:0] full_mask;
    logic [mdet_pkg::MAX_ORDER-1:0] sub_mask;
    logic [mdet_pkg::IDX_W-1:0]   r_idx;
    logic                         r_done;
    logic                         bit_set;
    logic [mdet_pkg::ORD_W-1:0]   ones;
    logic [2*mdet_pkg::ORD_W-1:0] rn;
    logic [mdet_pkg::ADDR_W-1:0]  st_addr;
    logic [mdet_pkg::ROW_W-1:0]   acc_row;
    logic                         vneg;
    logic                         neg;
    logic [mdet_pkg::MAG_W-1:0]   mag;
    logic [mdet_pkg::LIMB_W-1:0]  b_limb;
    logic [mdet_pkg::MUL_W-1:0]   mul;
    logic [mdet_pkg::LIMB_W-1:0]  w;
    logic [mdet_pkg::LIMB_W:0]    sum;
    logic                         last_limb;
    logic                         sign;
    logic                         fits;
    logic [mdet_pkg::RES_W-1:0]   det_value;

    assign empty       = !out_valid_reg;
    assign determinant = det_reg;
    assign overflow    = ovf_reg;

    always_comb
    begin
        full_mask = mdet_pkg::MAX_ORDER'((33'(1) << order_reg) - 33'(1));
        r_idx     = r_reg[mdet_pkg::IDX_W-1:0];
        r_done    = (r_reg == order_reg);
        bit_set   = mask_reg[r_idx];
        sub_mask  = mask_reg ^ (mdet_pkg::MAX_ORDER'(1) << r_idx);
        ones      = '0;
        for (int i = 0; i < mdet_pkg::MAX_ORDER; i++)
        begin
            ones = ones + mdet_pkg::ORD_W'(mask_reg[i]);
        end
        rn      = (2*mdet_pkg::ORD_W)'(r_reg) * (2*mdet_pkg::ORD_W)'(order_reg)
                  + (2*mdet_pkg::ORD_W)'(c_reg);
        st_addr = mdet_pkg::ADDR_W'(rn);
        for (int i = 0; i < mdet_pkg::LIMBS; i++)
        begin
            acc_row[i*mdet_pkg::LIMB_W +: mdet_pkg::LIMB_W] = acc_reg[i];
        end

        vneg      = store_q_reg[mdet_pkg::ELEM_W-1];
        mag       = vneg ? mdet_pkg::MAG_W'(-store_q_reg) : mdet_pkg::MAG_W'(store_q_reg);
        neg       = (pos_reg[0] ^ c_reg[0]) ^ vneg;
        b_limb    = row_q_reg[limb_reg*mdet_pkg::LIMB_W +: mdet_pkg::LIMB_W];
        mul       = mdet_pkg::MUL_W'(b_limb) * mdet_pkg::MUL_W'(mag)
                    + mdet_pkg::MUL_W'((limb_reg == '0) ? '0 : mc_reg);
        w         = neg ? ~mul[mdet_pkg::LIMB_W-1:0] : mul[mdet_pkg::LIMB_W-1:0];
        sum       = (mdet_pkg::LIMB_W+1)'(acc_reg[limb_reg]) + (mdet_pkg::LIMB_W+1)'(w)
                    + (mdet_pkg::LIMB_W+1)'((limb_reg == '0) ? neg : ac_reg);
        last_limb = (32'(limb_reg) == mdet_pkg::LIMBS - 1);

        sign = acc_row[mdet_pkg::ROW_W-1];
        fits = sign ? (&acc_row[mdet_pkg::ROW_W-1:mdet_pkg::RES_W-1])
                    : (~|acc_row[mdet_pkg::ROW_W-1:mdet_pkg::RES_W-1]);
        if (fits)
        begin
            det_value = acc_row[mdet_pkg::RES_W-1:0];
        end
        else if (sign)
        begin
            det_value = {1'b1, {(mdet_pkg::RES_W-1){1'b0}}};
        end
        else
        begin
            det_value = {1'b0, {(mdet_pkg::RES_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fifo_rd    = 1'b0;
        case (state_reg)
            mdet_pkg::B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_rd = 1'b1;
                    if (fifo_entry.last)
                    begin
                        state_next = mdet_pkg::B_INIT;
                    end
                end
            end
            mdet_pkg::B_INIT:
            begin
                state_next = mdet_pkg::B_MASK;
            end
            mdet_pkg::B_MASK:
            begin
                state_next = mdet_pkg::B_ROW;
            end
            mdet_pkg::B_ROW:
            begin
                if (r_done)
                begin
                    state_next = (mask_reg == full_mask) ? mdet_pkg::B_DONE : mdet_pkg::B_MASK;
                end
                else if (bit_set)
                begin
                    state_next = mdet_pkg::B_MAC;
                end
            end
            mdet_pkg::B_MAC:
            begin
                if (last_limb)
                begin
                    state_next = mdet_pkg::B_ROW;
                end
            end
            mdet_pkg::B_DONE:
            begin
                if (!out_valid_reg)
                begin
                    state_next = mdet_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mdet_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mdet_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_rd)
        begin
            store_mem[fifo_entry.addr] <= fifo_entry.element;
        end
        if (state_reg == mdet_pkg::B_ROW && !r_done && bit_set)
        begin
            store_q_reg <= store_mem[st_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mdet_pkg::B_INIT)
        begin
            minor_mem[0] <= mdet_pkg::ROW_W'(1);
        end
        else if (state_reg == mdet_pkg::B_ROW && r_done)
        begin
            minor_mem[mask_reg] <= acc_row;
        end
        if (state_reg == mdet_pkg::B_ROW && !r_done && bit_set)
        begin
            row_q_reg <= minor_mem[sub_mask];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mdet_pkg::B_IDLE:
            begin
                if (fifo_rd)
                begin
                    order_reg <= fifo_entry.order;
                end
            end
            mdet_pkg::B_INIT:
            begin
                mask_reg <= mdet_pkg::MAX_ORDER'(1);
            end
            mdet_pkg::B_MASK:
            begin
                for (int i = 0; i < mdet_pkg::LIMBS; i++)
                begin
                    acc_reg[i] <= '0;
                end
                r_reg   <= '0;
                pos_reg <= '0;
                c_reg   <= mdet_pkg::IDX_W'(ones - mdet_pkg::ORD_W'(1));
            end
            mdet_pkg::B_ROW:
            begin
                if (r_done)
                begin
                    mask_reg <= mask_reg + mdet_pkg::MAX_ORDER'(1);
                end
                else if (bit_set)
                begin
                    limb_reg <= '0;
                end
                else
                begin
                    r_reg <= r_reg + mdet_pkg::ORD_W'(1);
                end
            end
            mdet_pkg::B_MAC:
            begin
                acc_reg[limb_reg] <= sum[mdet_pkg::LIMB_W-1:0];
                ac_reg            <= sum[mdet_pkg::LIMB_W];
                mc_reg            <= mul[mdet_pkg::MUL_W-1:mdet_pkg::LIMB_W];
                limb_reg          <= limb_reg + mdet_pkg::LIMB_IW'(1);
                if (last_limb)
                begin
                    r_reg   <= r_reg + mdet_pkg::ORD_W'(1);
                    pos_reg <= pos_reg + mdet_pkg::ORD_W'(1);
                end
            end
            mdet_pkg::B_DONE:
            begin
                if (!out_valid_reg)
                begin
                    det_reg <= det_value;
                    ovf_reg <= !fits;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == mdet_pkg::B_DONE && !out_valid_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[rtl/matrix_determinant.sv]
// Top level of the matrix determinant block: front end, request queue and engine.
`timescale 1ns / 1ps
`default_nettype none
// The order (1 to 8; 0 acts as 1, larger values as 8) is written through cfg_wr_en and
// cfg_wr_data, which the user must do only while the block is idle (the block does not
// enforce this); a write restarts loading at the first element. Elements arrive in
// row-major order, one request per cycle while full is low, and each completed matrix
// gives one result with its exact determinant saturated to 64 bits and an overflow flag.
// The engine builds every minor of the first columns over all row subsets, one 32 by 16
// bit multiply-accumulate per cycle in its MAC state, on 192-bit values kept in a
// 256-row minor table.
module matrix_determinant (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [mdet_pkg::ELEM_W-1:0]  element,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [mdet_pkg::RES_W-1:0]        determinant,
    output logic                                     overflow,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mdet_pkg::CFG_W-1:0]          cfg_wr_data
);

    mdet_pkg::entry_t wr_entry;
    mdet_pkg::entry_t rd_entry;
    logic             fifo_wr;
    logic             fifo_rd;
    logic             fifo_empty;

    mdet_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .element     (element),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fifo_full   (full),
        .fifo_wr     (fifo_wr),
        .fifo_entry  (wr_entry)
    );

    mdet_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (fifo_wr),
        .wr_entry (wr_entry),
        .full     (full),
        .rd       (fifo_rd),
        .rd_entry (rd_entry),
        .empty    (fifo_empty)
    );

    mdet_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .fifo_entry  (rd_entry),
        .fifo_rd     (fifo_rd),
        .determinant (determinant),
        .overflow    (overflow),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
`default_nettype wire

[tb/matrix_determinant_test.sv]
// Testbench for the matrix determinant block: directed table, random phases, self-checking.
`timescale 1ns / 1ps
module matrix_determinant_test;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int WIDE_W = 192;

    typedef struct {
        logic signed [mdet_pkg::RES_W-1:0] det;
        logic                              ovf;
    } det_result_t;

    typedef struct {
        bit                                 wr;
        logic [mdet_pkg::CFG_W-1:0]         order_val;
        logic signed [mdet_pkg::ELEM_W-1:0] val;
        bit                                 known;
        logic signed [mdet_pkg::RES_W-1:0]  det;
        logic                               ovf;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic signed [mdet_pkg::ELEM_W-1:0] element = '0;
    logic pop = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [mdet_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic full;
    logic empty;
    logic signed [mdet_pkg::RES_W-1:0] determinant;
    logic overflow;

    matrix_determinant dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .element(element),
        .empty(empty),
        .pop(pop),
        .determinant(determinant),
        .overflow(overflow),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #2 clk = ~clk;

    logic [mdet_pkg::CFG_W-1:0] order_shadow;
    logic signed [mdet_pkg::ELEM_W-1:0] entries [mdet_pkg::STORE_DEPTH];
    int loaded;
    det_result_t pending_dets[$];
    stim_row_t dir_tbl[$];
    int mismatches = 0;
    int cycles = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    function automatic int active_order();
        if (order_shadow == 0)
            return 1;
        if (order_shadow > mdet_pkg::MAX_ORDER)
            return mdet_pkg::MAX_ORDER;
        return order_shadow;
    endfunction

    function automatic det_result_t expand_determinant(int n);
        logic signed [WIDE_W-1:0] minor_tbl [mdet_pkg::SUBSETS];
        logic signed [WIDE_W-1:0] term;
        det_result_t res;
        int full_mask;
        int col;
        int pos;
        full_mask = (1 << n) - 1;
        minor_tbl[0] = 1;
        for (int mask = 1; mask <= full_mask; mask++)
        begin
            col = $countones(mask) - 1;
            pos = 0;
            minor_tbl[mask] = 0;
            for (int r = 0; r < n; r++)
            begin
                if (mask[r])
                begin
                    term = WIDE_W'(entries[r * n + col]) * minor_tbl[mask ^ (1 << r)];
                    if (((pos + col) & 1) != 0)
                        minor_tbl[mask] = minor_tbl[mask] - term;
                    else
                        minor_tbl[mask] = minor_tbl[mask] + term;
                    pos++;
                end
            end
        end
        term = minor_tbl[full_mask];
        if (&term[WIDE_W-1:mdet_pkg::RES_W-1] || ~|term[WIDE_W-1:mdet_pkg::RES_W-1])
        begin
            res.det = term[mdet_pkg::RES_W-1:0];
            res.ovf = 1'b0;
        end
        else
        begin
            res.det = term[WIDE_W-1] ? {1'b1, {(mdet_pkg::RES_W-1){1'b0}}}
                                     : {1'b0, {(mdet_pkg::RES_W-1){1'b1}}};
            res.ovf = 1'b1;
        end
        return res;
    endfunction

    function automatic stim_row_t mk(bit wr, int ord, int val, bit known, longint det, bit ovf);
        stim_row_t row;
        row.wr = wr;
        row.order_val = ord[mdet_pkg::CFG_W-1:0];
        row.val = val[mdet_pkg::ELEM_W-1:0];
        row.known = known;
        row.det = det;
        row.ovf = ovf;
        return row;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        det_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_dets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: determinant=%0d overflow=%0b",
                             determinant, overflow);
            end
            else
            begin
                want = pending_dets.pop_front();
                if (determinant !== want.det || overflow !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected det=%0d ovf=%0b, got det=%0d ovf=%0b",
                                 want.det, want.ovf, determinant, overflow);
                end
            end
        end
    end

    // Returns 1 and the prediction when the request completes a matrix.
    task automatic send_element(input logic signed [mdet_pkg::ELEM_W-1:0] v, output bit done,
                                output det_result_t res);
        int n;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        element <= v;
        do
            @(posedge clk);
        while (full);
        n = active_order();
        entries[loaded] = v;
        loaded++;
        done = 1'b0;
        if (loaded == n * n)
        begin
            loaded = 0;
            done = 1'b1;
            res = expand_determinant(n);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (pending_dets.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_order(input logic [mdet_pkg::CFG_W-1:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        order_shadow = v;
        loaded = 0;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [mdet_pkg::ELEM_W-1:0] pick_element(int style);
        int sel;
        case (style)
            0: return mdet_pkg::ELEM_W'($urandom);
            1:
            begin
                sel = $urandom_range(4);
                case (sel)
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return -16'sd1;
                    3: return 16'sd0;
                    default: return 16'sd1;
                endcase
            end
            2: return mdet_pkg::ELEM_W'($urandom_range(8)) - 16'sd4;
            default: return ($urandom_range(1) == 0) ? mdet_pkg::ELEM_W'($urandom)
                                                     : pick_element(1);
        endcase
    endfunction

    initial
    begin
        int ph_cfg [10] = '{1, 2, 3, 4, 5, 6, 7, 15, 0, 2};
        int ph_cnt [10] = '{60, 25, 12, 8, 5, 3, 1, 1, 20, 10};
        int ph_tx [10] = '{0, 88, 0, 11, 0, 88, 11, 0, 0, 11};
        int ph_rx [10] = '{0, 0, 88, 11, 0, 0, 11, 88, 88, 11};
        bit done;
        det_result_t res;
        int n;
        int style;

        order_shadow = mdet_pkg::ORDER_RESET;
        loaded = 0;
        dir_tbl.push_back(mk(0, 0, 1, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 2, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 3, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 4, 1, -2, 0));
        dir_tbl.push_back(mk(1, 1, -32768, 1, -32768, 0));
        dir_tbl.push_back(mk(0, 0, 32767, 1, 32767, 0));
        dir_tbl.push_back(mk(0, 0, 0, 1, 0, 0));
        dir_tbl.push_back(mk(1, 0, -1, 1, -1, 0));
        dir_tbl.push_back(mk(1, 3, 5, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 7, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, -9, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 11, 0, 0, 0));
        dir_tbl.push_back(mk(1, 2, -32768, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 32767, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 32767, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, -32768, 1, 65535, 0));
        dir_tbl.push_back(mk(1, 15, 100, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, -200, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 300, 0, 0, 0));
        dir_tbl.push_back(mk(1, 2, 0, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, -1, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 1, 0, 0, 0));
        dir_tbl.push_back(mk(0, 0, 0, 1, 1, 0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].wr)
                write_order(dir_tbl[i].order_val);
            send_element(dir_tbl[i].val, done, res);
            if (dir_tbl[i].known)
            begin
                res.det = dir_tbl[i].det;
                res.ovf = dir_tbl[i].ovf;
                pending_dets.push_back(res);
            end
            else if (done)
                pending_dets.push_back(res);
        end

        for (int p = 0; p < 10; p++)
        begin
            write_order(ph_cfg[p][mdet_pkg::CFG_W-1:0]);
            tx_idle_pct = ph_tx[p];
            rx_stall_pct = ph_rx[p];
            n = active_order();
            for (int m = 0; m < ph_cnt[p]; m++)
            begin
                if (m == ph_cnt[p] / 2 && m != 0)
                    drain();
                style = $urandom_range(3);
                for (int k = 0; k < n * n; k++)
                begin
                    send_element(pick_element(style), done, res);
                    if (done)
                        pending_dets.push_back(res);
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/mdet_pkg.sv
rtl/mdet_front.sv
rtl/mdet_fifo.sv
rtl/mdet_back.sv
rtl/matrix_determinant.sv
tb/matrix_determinant_test.sv
